// ----- rtl/adp_pkg.sv -----
`timescale 1ns / 1ps

package adp_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_FLAGS     = 3'd0;
  localparam logic [2:0] KIND_FLAGS_ERR = 3'd1;
  localparam logic [2:0] KIND_UUID16    = 3'd2;
  localparam logic [2:0] KIND_NAME_BYTE = 3'd3;
  localparam logic [2:0] KIND_NAME_EMPT = 3'd4;
  localparam logic [2:0] KIND_KNOWN     = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd6;
  localparam logic [2:0] KIND_TRUNC     = 3'd7;

  // Structure types with dedicated handling.
  localparam logic [7:0] TYPE_FLAGS  = 8'h01;
  localparam logic [7:0] TYPE_UUID16 = 8'h03;
  localparam logic [7:0] TYPE_NAME   = 8'h09;

  // Flags codes and their classes.
  localparam logic [7:0] FLAG_LIMITED = 8'h01;
  localparam logic [7:0] FLAG_GENERAL = 8'h02;
  localparam logic [7:0] FLAG_NO_BREDR = 8'h04;
  localparam logic [7:0] FLAG_CTRL    = 8'h08;
  localparam logic [7:0] FLAG_HOST    = 8'h16;

  localparam logic [2:0] CLASS_LIMITED  = 3'd0;
  localparam logic [2:0] CLASS_GENERAL  = 3'd1;
  localparam logic [2:0] CLASS_NO_BREDR = 3'd2;
  localparam logic [2:0] CLASS_CTRL     = 3'd3;
  localparam logic [2:0] CLASS_HOST     = 3'd4;
  localparam logic [2:0] CLASS_RESERVED = 3'd5;

  localparam logic [15:0] FLAGS_ERR_VALUE = 16'h00ff;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  field_type;
    logic [15:0] value;
    logic [2:0]  flags_class;
  } res_t;

  // One queue entry holds every result caused by one input byte.
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } entry_t;

  function automatic logic type_known(input logic [7:0] t);
    logic k;
    k = 1'b0;
    if (t >= 8'h01 && t <= 8'h0a) k = 1'b1;
    if (t >= 8'h0d && t <= 8'h12) k = 1'b1;
    if (t >= 8'h14 && t <= 8'h2d) k = 1'b1;
    if (t == 8'h3d || t == 8'hff) k = 1'b1;
    return k;
  endfunction

  function automatic logic [2:0] flags_class_of(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      FLAG_LIMITED:  r = CLASS_LIMITED;
      FLAG_GENERAL:  r = CLASS_GENERAL;
      FLAG_NO_BREDR: r = CLASS_NO_BREDR;
      FLAG_CTRL:     r = CLASS_CTRL;
      FLAG_HOST:     r = CLASS_HOST;
      default:       r = CLASS_RESERVED;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/adp_in_if.sv -----
`timescale 1ns / 1ps

interface adp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

// ----- rtl/adp_out_if.sv -----
`timescale 1ns / 1ps

interface adp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  field_type;
  logic [15:0] value;
  logic [2:0]  flags_class;
  logic        last_result;

  modport source (output valid, output kind, output field_type, output value,
                  output flags_class, output last_result, input ready);
  modport sink (input valid, input kind, input field_type, input value,
                input flags_class, input last_result, output ready);
endinterface

// ----- rtl/adp_front.sv -----
`timescale 1ns / 1ps

module adp_front
  import adp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  adp_in_if.sink      payload,
  input  logic        full,
  output logic        push,
  output entry_t      push_entry
);

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0] phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] current_type, current_type_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] uuid_low_byte, uuid_low_byte_next;
  logic       pair_half, pair_half_next;
  logic [7:0] flags_byte, flags_byte_next;

  logic       accept;
  logic       prim_v;
  res_t       prim_r;
  logic       trunc_v;
  res_t       trunc_r;
  logic       open;
  logic [7:0] trunc_type;
  logic       fin_v;
  res_t       fin_r;
  logic [7:0] fin_type;
  logic [7:0] fin_len;
  logic [7:0] fin_flags;
  logic       fin_req;
  logic [7:0] b;
  logic [7:0] dec;

  assign payload.ready = !full;
  assign accept = payload.valid && !full;
  assign b = payload.data_byte;

  // End-of-structure result for the structure described by fin_*.
  always_comb begin
    fin_v = 1'b1;
    fin_r = '0;
    fin_r.field_type = fin_type;
    if (fin_type == TYPE_FLAGS) begin
      if (fin_len == 8'd1) begin
        fin_r.kind        = KIND_FLAGS;
        fin_r.value       = {8'h00, fin_flags};
        fin_r.flags_class = flags_class_of(fin_flags);
      end else begin
        fin_r.kind  = KIND_FLAGS_ERR;
        fin_r.value = FLAGS_ERR_VALUE;
      end
    end else if (fin_type == TYPE_UUID16) begin
      fin_v = 1'b0;
    end else if (fin_type == TYPE_NAME) begin
      fin_r.kind = KIND_NAME_EMPT;
      fin_v      = (fin_len == 8'd0);
    end else begin
      fin_r.kind = type_known(fin_type) ? KIND_KNOWN : KIND_UNKNOWN;
    end
  end

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    current_type_next   = current_type;
    payload_length_next = payload_length;
    uuid_low_byte_next  = uuid_low_byte;
    pair_half_next      = pair_half;
    flags_byte_next     = flags_byte;
    open       = 1'b0;
    trunc_type = 8'h00;
    prim_v     = 1'b0;
    prim_r     = '0;
    fin_req    = 1'b0;
    fin_type   = current_type;
    fin_len    = payload_length;
    fin_flags  = flags_byte;
    dec        = bytes_left - 8'd1;

    case (phase)
      PH_LEN: begin
        if (b != 8'h00) begin
          bytes_left_next = b;
          phase_next      = PH_TYPE;
          open            = 1'b1;
        end
      end
      PH_TYPE: begin
        current_type_next   = b;
        payload_length_next = dec;
        bytes_left_next     = dec;
        pair_half_next      = 1'b0;
        uuid_low_byte_next  = 8'h00;
        flags_byte_next     = 8'h00;
        fin_type  = b;
        fin_len   = dec;
        fin_flags = 8'h00;
        if (dec == 8'h00) begin
          fin_req    = 1'b1;
          phase_next = PH_LEN;
        end else begin
          phase_next = PH_DATA;
          open       = 1'b1;
          trunc_type = b;
        end
      end
      default: begin
        bytes_left_next = dec;
        if (current_type == TYPE_FLAGS) begin
          flags_byte_next = b;
          fin_flags       = b;
        end else if (current_type == TYPE_UUID16) begin
          if (!payload_length[0]) begin
            if (!pair_half) begin
              uuid_low_byte_next = b;
              pair_half_next     = 1'b1;
            end else begin
              prim_v             = 1'b1;
              prim_r.kind        = KIND_UUID16;
              prim_r.field_type  = current_type;
              prim_r.value       = {b, uuid_low_byte};
              pair_half_next     = 1'b0;
            end
          end
        end else if (current_type == TYPE_NAME) begin
          prim_v            = 1'b1;
          prim_r.kind       = KIND_NAME_BYTE;
          prim_r.field_type = current_type;
          prim_r.value      = {8'h00, b};
        end
        if (dec == 8'h00) begin
          fin_req    = 1'b1;
          phase_next = PH_LEN;
        end else begin
          open       = 1'b1;
          trunc_type = current_type;
        end
      end
    endcase

    // A data byte never emits alongside a finishing result, so one slot holds either.
    if (fin_req && fin_v) begin
      prim_v = 1'b1;
      prim_r = fin_r;
    end

    trunc_v            = payload.frame_end && open;
    trunc_r            = '0;
    trunc_r.kind       = KIND_TRUNC;
    trunc_r.field_type = trunc_type;
    if (payload.frame_end) begin
      phase_next      = PH_LEN;
      bytes_left_next = 8'h00;
    end
  end

  always_comb begin
    push_entry.first  = prim_v ? prim_r : trunc_r;
    push_entry.second = trunc_r;
    push_entry.two    = prim_v && trunc_v;
    push              = accept && (prim_v || trunc_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      bytes_left     <= 8'h00;
      current_type   <= 8'h00;
      payload_length <= 8'h00;
      uuid_low_byte  <= 8'h00;
      pair_half      <= 1'b0;
      flags_byte     <= 8'h00;
    end else if (accept) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      current_type   <= current_type_next;
      payload_length <= payload_length_next;
      uuid_low_byte  <= uuid_low_byte_next;
      pair_half      <= pair_half_next;
      flags_byte     <= flags_byte_next;
    end
  end

endmodule

// ----- rtl/adp_queue.sv -----
`timescale 1ns / 1ps

module adp_queue
  import adp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  entry_t        store [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_FULL);
  assign head      = store[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/adp_back.sv -----
`timescale 1ns / 1ps

module adp_back
  import adp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  logic      not_empty,
  output logic      pop,
  adp_out_if.source result
);

  logic sub;
  logic xfer;
  res_t cur;

  assign cur  = sub ? head.second : head.first;
  assign xfer = not_empty && result.ready;
  assign pop  = xfer && (sub || !head.two);

  assign result.valid       = not_empty;
  assign result.kind        = cur.kind;
  assign result.field_type  = cur.field_type;
  assign result.value       = cur.value;
  assign result.flags_class = cur.flags_class;
  assign result.last_result = sub || !head.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (xfer) begin
      sub <= !pop;
    end
  end

endmodule

// ----- rtl/adv_data_structure_parser.sv -----
`timescale 1ns / 1ps

// Advertising-data structure parser.
// The payload channel carries one advertising byte per transfer, with
// frame_end set on the final byte of the frame. The result channel carries
// the parsed results (flags, 16-bit UUIDs, name bytes, reports for other
// types and truncation), each with last_result set on the final result that
// its input byte caused. Bytes that cause no result produce no transfer.
// The front end tracks the length-type-value structure state and accepts one
// byte every cycle while the queue is not full; it packs the results of each
// byte into one entry of a small queue (QUEUE_DEPTH entries). The back end
// shows the head entry on the result channel, one result per cycle while the
// receiver is ready, so a byte with two results takes two result transfers.
// Sustained throughput is one byte per cycle while results are taken;
// the result channel sets the pace otherwise.
// When the receiver stalls, the queue fills and payload ready falls once it
// is full; nothing is dropped. Reset (synchronous) empties the queue and
// returns the parser to expecting a length byte.

module adv_data_structure_parser
  import adp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  adp_in_if.sink    payload,
  adp_out_if.source result
);

  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   not_empty;
  logic   full;

  adp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .payload    (payload),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  adp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (full)
  );

  adp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- tb/adp_checker.sv -----
`timescale 1ns / 1ps

module adp_checker
  import adp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  adp_in_if    payload,
  adp_out_if   result,
  output int   errors,
  output int   pending,
  output int   bytes_seen,
  output int   results_seen
);

  localparam logic [2:0] NO_CLASS = 3'd0;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {AWAIT_LEN, AWAIT_TYPE, IN_PAYLOAD} parse_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  field_type;
    logic [15:0] value;
    logic [2:0]  flags_class;
    logic        last_result;
  } ad_result_t;

  parse_phase_t phase;
  logic [7:0]   bytes_left;
  logic [7:0]   cur_type;
  logic [7:0]   payload_len;
  logic [7:0]   uuid_lo;
  logic [7:0]   flags_code;
  logic         pair_half;

  ad_result_t   expected_results[$];

  function automatic logic is_known_type(input logic [7:0] t);
    return t inside {[8'h01:8'h0a], [8'h0d:8'h12], [8'h14:8'h2d], 8'h3d, 8'hff};
  endfunction

  function automatic logic [2:0] class_of_flags(input logic [7:0] code);
    logic [2:0] c;
    case (code)
      FLAG_LIMITED:  c = CLASS_LIMITED;
      FLAG_GENERAL:  c = CLASS_GENERAL;
      FLAG_NO_BREDR: c = CLASS_NO_BREDR;
      FLAG_CTRL:     c = CLASS_CTRL;
      FLAG_HOST:     c = CLASS_HOST;
      default:       c = CLASS_RESERVED;
    endcase
    return c;
  endfunction

  task automatic push_result(input logic [2:0] k, input logic [7:0] t, input logic [15:0] v,
                             input logic [2:0] c, inout int produced);
    ad_result_t r;
    r.kind        = k;
    r.field_type  = t;
    r.value       = v;
    r.flags_class = c;
    r.last_result = 1'b0;
    expected_results.insert(expected_results.size(), r);
    produced++;
  endtask

  // Report owed when a structure completes.
  task automatic close_structure(inout int produced);
    if (cur_type == TYPE_FLAGS) begin
      if (payload_len == 8'd1) begin
        push_result(KIND_FLAGS, cur_type, {8'h00, flags_code}, class_of_flags(flags_code),
                    produced);
      end else begin
        push_result(KIND_FLAGS_ERR, cur_type, FLAGS_ERR_VALUE, NO_CLASS, produced);
      end
    end else if (cur_type == TYPE_NAME) begin
      if (payload_len == 8'd0) begin
        push_result(KIND_NAME_EMPT, cur_type, 16'h0000, NO_CLASS, produced);
      end
    end else if (cur_type != TYPE_UUID16) begin
      push_result(is_known_type(cur_type) ? KIND_KNOWN : KIND_UNKNOWN, cur_type, 16'h0000,
                  NO_CLASS, produced);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fend);
    int         produced;
    logic       still_open;
    logic [7:0] trunc_type;
    produced   = 0;
    still_open = 1'b0;
    trunc_type = 8'h00;
    case (phase)
      AWAIT_LEN: begin
        if (b != 8'h00) begin
          bytes_left = b;
          phase      = AWAIT_TYPE;
          still_open = 1'b1;
        end
      end
      AWAIT_TYPE: begin
        cur_type    = b;
        payload_len = bytes_left - 8'd1;
        bytes_left  = payload_len;
        pair_half   = 1'b0;
        uuid_lo     = 8'h00;
        flags_code  = 8'h00;
        if (payload_len == 8'd0) begin
          close_structure(produced);
          phase = AWAIT_LEN;
        end else begin
          phase      = IN_PAYLOAD;
          still_open = 1'b1;
          trunc_type = b;
        end
      end
      default: begin
        bytes_left = bytes_left - 8'd1;
        if (cur_type == TYPE_FLAGS) begin
          flags_code = b;
        end else if (cur_type == TYPE_UUID16) begin
          // Odd-length lists are dropped silently.
          if (!payload_len[0]) begin
            if (!pair_half) begin
              uuid_lo   = b;
              pair_half = 1'b1;
            end else begin
              push_result(KIND_UUID16, cur_type, {b, uuid_lo}, NO_CLASS, produced);
              pair_half = 1'b0;
            end
          end
        end else if (cur_type == TYPE_NAME) begin
          push_result(KIND_NAME_BYTE, cur_type, {8'h00, b}, NO_CLASS, produced);
        end
        if (bytes_left == 8'd0) begin
          close_structure(produced);
          phase = AWAIT_LEN;
        end else begin
          still_open = 1'b1;
          trunc_type = cur_type;
        end
      end
    endcase
    if (fend) begin
      if (still_open) begin
        push_result(KIND_TRUNC, trunc_type, 16'h0000, NO_CLASS, produced);
      end
      phase      = AWAIT_LEN;
      bytes_left = 8'h00;
    end
    if (produced > 0) begin
      expected_results[expected_results.size() - 1].last_result = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    ad_result_t got;
    ad_result_t want;
    if (rst) begin
      phase        = AWAIT_LEN;
      bytes_left   = 8'h00;
      cur_type     = 8'h00;
      payload_len  = 8'h00;
      uuid_lo      = 8'h00;
      flags_code   = 8'h00;
      pair_half    = 1'b0;
      expected_results.delete();
      errors       = 0;
      bytes_seen   = 0;
      results_seen = 0;
    end else begin
      if (payload.valid && payload.ready) begin
        parse_byte(payload.data_byte, payload.frame_end);
        bytes_seen++;
      end
      if (result.valid && result.ready) begin
        got.kind        = result.kind;
        got.field_type  = result.field_type;
        got.value       = result.value;
        got.flags_class = result.flags_class;
        got.last_result = result.last_result;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("adp_checker: result %0d arrived with nothing expected:", results_seen);
            $display("  kind=%0d type=%02h value=%04h class=%0d last=%0b",
                     got.kind, got.field_type, got.value, got.flags_class,
                     got.last_result);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("adp_checker: result %0d mismatch:", results_seen);
              $display("  expected kind=%0d type=%02h value=%04h class=%0d last=%0b",
                       want.kind, want.field_type, want.value, want.flags_class,
                       want.last_result);
              $display("  got      kind=%0d type=%02h value=%04h class=%0d last=%0b",
                       got.kind, got.field_type, got.value, got.flags_class,
                       got.last_result);
            end
          end
        end
        results_seen++;
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the advertising-data parser. The checker beside
// the block watches both channels, predicts every result and compares; this
// module only offers payload bytes, paces the result receiver and decides the
// outcome once everything has drained.

module tb_top
  import adp_pkg::*;
();

  localparam int ITEMS          = 750;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  // Directed opening: bit 8 is frame_end, bits 7:0 the payload byte.
  localparam logic [8:0] DIRECTED [26] = '{
    9'h000,                                  // padding byte
    9'h002, 9'h001, 9'h016,                  // flags, host class
    9'h001, 9'h001,                          // flags with an empty payload
    9'h005, 9'h003, 9'h034, 9'h012, 9'h0ff, 9'h0ff,  // two UUIDs, one all ones
    9'h002, 9'h003, 9'h000,                  // UUID list of odd length
    9'h001, 9'h009,                          // empty name
    9'h001, 9'h0ff,                          // known type, nothing parsed
    9'h004, 9'h009, 9'h141,                  // name byte, then the frame is cut off
    9'h1ff,                                  // cut off straight after the length
    9'h002, 9'h009, 9'h180                   // frame ends exactly on a complete name
  };

  localparam logic [7:0] KNOWN_TYPES [8] = '{
    8'h02, 8'h06, 8'h0a, 8'h0d, 8'h12, 8'h14, 8'h2d, 8'h3d
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  int mismatches;
  int pending;
  int bytes_checked;
  int results_checked;

  int bytes_sent  = 0;
  int frames_sent = 0;
  int stall_req   = 0;
  int stall_ack   = 0;
  int send_calm   = 0;
  int recv_calm   = 0;

  logic [7:0] frame_q[$];

  always #4 clk = ~clk;

  adp_in_if  payload ();
  adp_out_if result ();

  adv_data_structure_parser i_dut (
    .clk     (clk),
    .rst     (rst),
    .payload (payload),
    .result  (result)
  );

  adp_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .payload      (payload),
    .result       (result),
    .errors       (mismatches),
    .pending      (pending),
    .bytes_seen   (bytes_checked),
    .results_seen (results_checked)
  );

  // Idle gap before the next transfer on either side. Most gaps are zero or
  // short and a few are long; now and then a calm stretch with no gaps at all
  // starts, counted down in the caller's own counter.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one byte and returns at the falling edge after its transfer.
  // It is entered at a falling edge, so every change to the payload channel
  // happens away from the rising edge at which the block samples it. Valid is
  // only lowered when a gap is really wanted, so back-to-back bytes keep it
  // high with a single assignment per time step.
  task automatic send_byte(input logic [7:0] b, input logic fend);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      payload.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    payload.valid     <= 1'b1;
    payload.data_byte <= b;
    payload.frame_end <= fend;
    do @(posedge clk); while (!payload.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Appends one length-type-value structure to the frame under construction.
  // Lengths are mostly small; a rare long name pushes the length byte into
  // its upper range.
  task automatic add_structure();
    int         pick;
    int         plen;
    logic [7:0] stype;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      frame_q.insert(frame_q.size(), 8'h00);
    end else begin
      if (pick < 26) begin
        stype = TYPE_FLAGS;
        plen  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1;
      end else if (pick < 44) begin
        stype = TYPE_UUID16;
        plen  = 2 * $urandom_range(0, 4);
        if ($urandom_range(0, 4) == 0) plen = plen + 1;
      end else if (pick < 68) begin
        stype = TYPE_NAME;
        plen  = ($urandom_range(0, 79) == 0) ? $urandom_range(120, 254) : $urandom_range(0, 8);
      end else if (pick < 84) begin
        stype = KNOWN_TYPES[$urandom_range(0, 7)];
        plen  = $urandom_range(0, 5);
      end else begin
        stype = 8'($urandom_range(0, 255));
        plen  = $urandom_range(0, 5);
      end
      frame_q.insert(frame_q.size(), 8'(plen + 1));
      frame_q.insert(frame_q.size(), stype);
      if (stype == TYPE_FLAGS && plen == 1) begin
        // Well-formed flags mostly carry one of the defined codes.
        case ($urandom_range(0, 6))
          0:       code = FLAG_LIMITED;
          1:       code = FLAG_GENERAL;
          2:       code = FLAG_NO_BREDR;
          3:       code = FLAG_CTRL;
          4:       code = FLAG_HOST;
          default: code = 8'($urandom_range(0, 255));
        endcase
        frame_q.insert(frame_q.size(), code);
      end else begin
        for (int i = 0; i < plen; i++) begin
          frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Builds one frame: mostly a few well-formed structures, sometimes cut off
  // part-way so that truncation is reported, and sometimes plain noise.
  task automatic build_frame();
    int cut;
    frame_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) add_structure();
      if ($urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, frame_q.size());
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  // Payload side: reset, the directed opening, then random frames until the
  // byte budget is spent, then drain and give the verdict.
  initial begin
    logic end_mark;
    payload.valid     = 1'b0;
    payload.data_byte = 8'h00;
    payload.frame_end = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[d]) send_byte(DIRECTED[d][7:0], DIRECTED[d][8]);

    while (bytes_sent < ITEMS) begin
      // Early on, and again now and then, the receiver is asked to hold off
      // for a long stretch while bytes keep coming, so that the result queue
      // fills and the block has to refuse payload transfers.
      if (frames_sent % 40 == 2) stall_req++;
      build_frame();
      // A few frames run on into the next one without an end mark.
      end_mark = ($urandom_range(0, 19) != 0);
      foreach (frame_q[k]) send_byte(frame_q[k], end_mark && (k == frame_q.size() - 1));
      frames_sent++;
    end
    payload.valid <= 1'b0;

    // Wait for every predicted result, then a little longer so that any
    // surplus result still has time to show up.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb_top: %0d payload bytes in %0d random frames after the directed opening,",
             bytes_checked, frames_sent);
    $display("tb_top: %0d results compared across flags, UUID lists, names, other types,",
             results_checked);
    $display("tb_top: padding, noise and cut-off ends, with %0d long receiver hold-offs",
             stall_ack);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Result side: random readiness, with a long hold-off whenever the payload
  // side asks for one. The hold-off is counted here, independent of how the
  // payload side is progressing.
  initial begin
    int gap;
    result.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (stall_req != stall_ack) begin
        result.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        stall_ack++;
      end else begin
        gap = pick_gap(recv_calm);
        if (gap > 0) begin
          result.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        result.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for too
  // long. The limit is well above the longest receiver hold-off.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((payload.valid && payload.ready) || (result.valid && result.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_top: watchdog expired, no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- adv_data_structure_parser.f -----
rtl/adp_pkg.sv
rtl/adp_in_if.sv
rtl/adp_out_if.sv
rtl/adp_front.sv
rtl/adp_queue.sv
rtl/adp_back.sv
rtl/adv_data_structure_parser.sv
tb/adp_checker.sv
tb/tb_top.sv
